FILE: src/assert_macros.svh
// Assertion macros for the checker file of the buffer pool free list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts a property on every rising edge of clk outside reset.
`define BPFL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Asserts that the consequent holds in the cycle after the antecedent.
`define BPFL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bpfl_pkg.sv
// Package with the types, codes and constants of the buffer pool free list.
package bpfl_pkg;

    localparam int MAX_BUFFERS_DEF = 256;
    localparam int POOL_LIMIT      = 256;
    localparam int IDX_W           = 8;
    localparam int COUNT_W         = 9;
    localparam int STATUS_W        = 2;
    localparam int PADDR_W         = 2;
    localparam int PDATA_W         = 32;

    localparam int WATERMARK_PCT   = 20;
    localparam int PERCENT_BASE    = 100;
    // The pool size times WM_MULT, shifted right by WM_SHIFT, equals the pool size times
    // 20/100 rounded down for every size below 1024.
    localparam int WM_SHIFT        = 10;
    localparam int WM_MULT         = ((1 << WM_SHIFT) * WATERMARK_PCT + PERCENT_BASE - 1)
                                     / PERCENT_BASE;
    localparam int WM_PROD_W       = COUNT_W + 8;

    localparam logic [COUNT_W-1:0] POOL_SIZE_RESET = COUNT_W'(256);

    localparam logic [PADDR_W-1:0] REG_POOL_SIZE = PADDR_W'(0);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_RANGE = STATUS_W'(2);

    typedef struct packed {
        logic init_start;
        logic init_step;
        logic accept;
        logic pop_load;
    } bpfl_cmd_t;

    typedef struct packed {
        logic cfg_write;
        logic init_last;
        logic alloc_ok;
    } bpfl_stat_t;

endpackage

FILE: src/bpfl_req_if.sv
// Request channel interface: operation and buffer index with a valid/ready handshake.
interface bpfl_req_if import bpfl_pkg::*;;
    logic             valid;
    logic             ready;
    logic             operation;
    logic [IDX_W-1:0] buffer_index;

    modport source (output valid, operation, buffer_index, input ready);
    modport sink (input valid, operation, buffer_index, output ready);
    modport monitor (input valid, ready, operation, buffer_index);
endinterface

FILE: src/bpfl_rsp_if.sv
// Result channel interface: allocation result and status with a valid/ready handshake.
interface bpfl_rsp_if import bpfl_pkg::*;;
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    alloc_index;
    logic [STATUS_W-1:0] status;
    logic                low_warning;
    logic [COUNT_W-1:0]  free_count;

    modport source (output valid, alloc_index, status, low_warning, free_count, input ready);
    modport sink (input valid, alloc_index, status, low_warning, free_count, output ready);
    modport monitor (input valid, ready, alloc_index, status, low_warning, free_count);
endinterface

FILE: src/bpfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bpfl_ctrl.sv
// Controller state machine: init pass, accepting transfers, pop cycle and result valid.
module bpfl_ctrl import bpfl_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  bpfl_stat_t stat,
    output bpfl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_INIT = 3'b001,
        ST_IDLE = 3'b010,
        ST_POP  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.init_start = stat.cfg_write;
        cmd.init_step  = (state_reg == ST_INIT) && !stat.cfg_write;
        cmd.accept     = accept;
        cmd.pop_load   = (state_reg == ST_POP);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (stat.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && stat.alloc_ok)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
        if (stat.cfg_write)
        begin
            state_next = ST_INIT;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: src/bpfl_dp.sv
// Datapath: pool size register, link memory, head, free counter, watermark and result register.
module bpfl_dp import bpfl_pkg::*; #(
    parameter int MAX_BUFFERS = MAX_BUFFERS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    input  logic                in_operation,
    input  logic [IDX_W-1:0]    in_buffer_index,
    output logic [IDX_W-1:0]    out_alloc_index,
    output logic [STATUS_W-1:0] out_status,
    output logic                out_low_warning,
    output logic [COUNT_W-1:0]  out_free_count,
    input  bpfl_cmd_t           cmd,
    output bpfl_stat_t          stat
);

    localparam int POOL_MAX = (MAX_BUFFERS < POOL_LIMIT) ? MAX_BUFFERS : POOL_LIMIT;
    localparam int ADDR_W   = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1;

    logic [COUNT_W-1:0]  pool_size_reg;
    logic [COUNT_W-1:0]  init_ptr_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]    watermark_reg;
    logic [IDX_W-1:0]    alloc_index_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                low_warning_reg;
    logic [COUNT_W-1:0]  free_count_reg;

    logic [COUNT_W-1:0]   pool_eff;
    logic [WM_PROD_W-1:0] wm_prod;
    logic [IDX_W-1:0]     wm_value;
    logic [IDX_W-1:0]     init_link;
    logic                 init_last;
    logic                 alloc_ok;
    logic                 free_ok;
    logic [COUNT_W-1:0]   count_inc;
    logic [COUNT_W-1:0]   count_dec;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [IDX_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_rdata;

    always_comb
    begin
        if (pool_size_reg == '0)
        begin
            pool_eff = COUNT_W'(1);
        end
        else if (pool_size_reg > COUNT_W'(POOL_MAX))
        begin
            pool_eff = COUNT_W'(POOL_MAX);
        end
        else
        begin
            pool_eff = pool_size_reg;
        end
    end

    assign wm_prod  = WM_PROD_W'(pool_eff) * WM_PROD_W'(WM_MULT);
    assign wm_value = IDX_W'(wm_prod >> WM_SHIFT);

    assign init_last = (init_ptr_reg == (pool_eff - COUNT_W'(1)));
    assign init_link = init_last ? '0 : IDX_W'(init_ptr_reg + COUNT_W'(1));

    assign alloc_ok  = (in_operation == OP_ALLOC) && (count_reg != '0);
    assign free_ok   = (in_operation == OP_FREE) && ({1'b0, in_buffer_index} < pool_eff);
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);
    assign count_dec = count_reg - COUNT_W'(1);

    always_comb
    begin
        stat.cfg_write = psel && penable && pwrite && (paddr == REG_POOL_SIZE);
        stat.init_last = init_last;
        stat.alloc_ok  = alloc_ok;
    end

    assign prdata = (paddr == REG_POOL_SIZE) ? PDATA_W'(pool_size_reg) : '0;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = init_ptr_reg[ADDR_W-1:0];
        ram_wdata = init_link;
        if (cmd.init_step)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.accept && free_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = in_buffer_index[ADDR_W-1:0];
            ram_wdata = head_reg;
        end
    end

    bpfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_MAX)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= POOL_SIZE_RESET;
            init_ptr_reg  <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            watermark_reg <= '0;
        end
        else
        begin
            if (stat.cfg_write)
            begin
                pool_size_reg <= pwdata[COUNT_W-1:0];
            end

            if (cmd.init_start)
            begin
                init_ptr_reg <= '0;
            end
            else if (cmd.init_step)
            begin
                init_ptr_reg <= init_ptr_reg + COUNT_W'(1);
            end

            if (cmd.init_step && init_last)
            begin
                head_reg      <= '0;
                count_reg     <= pool_eff;
                watermark_reg <= wm_value;
            end
            else if (cmd.pop_load)
            begin
                head_reg <= ram_rdata;
            end
            else if (cmd.accept && alloc_ok)
            begin
                count_reg <= count_dec;
            end
            else if (cmd.accept && free_ok)
            begin
                head_reg  <= in_buffer_index;
                count_reg <= count_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            alloc_index_reg <= '0;
            low_warning_reg <= 1'b0;
            status_reg      <= STATUS_OK;
            free_count_reg  <= count_reg;
            if (in_operation == OP_ALLOC)
            begin
                if (alloc_ok)
                begin
                    alloc_index_reg <= head_reg;
                    low_warning_reg <= (count_reg < {1'b0, watermark_reg});
                    free_count_reg  <= count_dec;
                end
                else
                begin
                    status_reg <= STATUS_EMPTY;
                end
            end
            else
            begin
                if (free_ok)
                begin
                    free_count_reg <= count_inc;
                end
                else
                begin
                    status_reg <= STATUS_RANGE;
                end
            end
        end
    end

    assign out_alloc_index = alloc_index_reg;
    assign out_status      = status_reg;
    assign out_low_warning = low_warning_reg;
    assign out_free_count  = free_count_reg;

endmodule

FILE: src/buffer_pool_free_list.sv
// Top level of the buffer pool free list allocator.
//
// The req channel carries one operation per transfer: allocate (operation 0) pops the
// head of a LIFO free list, free (operation 1) pushes buffer_index. Every request gives
// exactly one transfer on the rsp channel with alloc_index, status, low_warning and the
// free count after the operation. pool_size is written over the APB port at address 0.
// After reset, and after every write of pool_size, an init pass links the buffers in
// order, one link memory entry a cycle, over the pool size held to the range 1 to
// MAX_BUFFERS capped at 256 (256 after reset), with req.ready low throughout. The result
// is registered and appears in the cycle after the request transfer. After a free or a
// rejected request the block stays idle; a successful allocate first passes through
// the pop state, because the link of the popped head comes from the registered read
// of the link memory before the next request is taken. A result register decouples
// the sides: a new request is taken while the result is being transferred, and while
// rsp is stalled with a result pending the block takes no new request.
module buffer_pool_free_list import bpfl_pkg::*; #(
    parameter int MAX_BUFFERS = MAX_BUFFERS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    bpfl_req_if.sink            req,
    bpfl_rsp_if.source          rsp
);

    bpfl_cmd_t  cmd;
    bpfl_stat_t stat;

    assign pready = 1'b1;

    bpfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpfl_dp #(
        .MAX_BUFFERS (MAX_BUFFERS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .in_operation    (req.operation),
        .in_buffer_index (req.buffer_index),
        .out_alloc_index (rsp.alloc_index),
        .out_status      (rsp.status),
        .out_low_warning (rsp.low_warning),
        .out_free_count  (rsp.free_count),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

FILE: src/bpfl_checker.sv
// Port-level checker for the buffer pool free list, bound to the top level.
`include "assert_macros.svh"

module bpfl_checker import bpfl_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [IDX_W-1:0]    rsp_alloc_index,
    input logic [STATUS_W-1:0] rsp_status,
    input logic                rsp_low_warning,
    input logic [COUNT_W-1:0]  rsp_free_count
);

    logic                             rsp_error;
    logic                             reject_clean;
    logic                             rsp_stall;
    logic [IDX_W+STATUS_W+COUNT_W:0] rsp_payload;

    assign rsp_error    = rsp_valid && (rsp_status != STATUS_OK);
    assign reject_clean = (rsp_alloc_index == '0) && !rsp_low_warning;
    assign rsp_stall    = rsp_valid && !rsp_ready;
    assign rsp_payload  = {rsp_alloc_index, rsp_status, rsp_low_warning, rsp_free_count};

    // Every request transfer produces a pending result in the next cycle.
    `BPFL_ASSERT_NEXT(a_result_follows, req_valid && req_ready, rsp_valid, "no result after request")

    // A rejected operation reports no buffer and no warning.
    `BPFL_ASSERT(a_reject_clean, !rsp_error || reject_clean, "rejected operation with payload")

    // The warning never accompanies a rejected operation.
    `BPFL_ASSERT(a_warn_ok, !rsp_error || !rsp_low_warning, "warning with error status")

    // A stalled result keeps its payload.
    `BPFL_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")

endmodule

bind buffer_pool_free_list bpfl_checker u_bpfl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_alloc_index (rsp.alloc_index),
    .rsp_status      (rsp.status),
    .rsp_low_warning (rsp.low_warning),
    .rsp_free_count  (rsp.free_count)
);
